// ===== hw/rtl/disc_column_span_generator_core_macros.svh =====
// Assertion macros shared by the disc column span generator RTL.
`ifndef DISC_COLUMN_SPAN_GENERATOR_CORE_MACROS_SVH
`define DISC_COLUMN_SPAN_GENERATOR_CORE_MACROS_SVH

// Check cons in the same cycle as ante; needs clk and arst_n in scope.
`define DCSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante; needs clk and arst_n in scope.
`define DCSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dcsg_pkg.sv =====
// Shared constants and types of the disc column span generator.
`timescale 1ns / 1ps

package dcsg_pkg;

	localparam int MAP_DIM_DEF    = 256;
	localparam int MAX_RADIUS_DEF = 31;

	localparam int CFG_DATA_W  = 9;
	localparam int CFG_INDEX_W = 1;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	typedef logic [CFG_DATA_W-1:0]  cfg_word_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_MAP_WIDTH  = 1'b0;
	localparam cfg_index_t REG_MAP_HEIGHT = 1'b1;

	localparam cfg_word_t MAP_REG_RESET = 9'd112;

endpackage

// ===== hw/rtl/disc_column_span_generator_core.sv =====
// Disc column span generator: one disc in, one vertical row span per covered column out.
`timescale 1ns / 1ps

// A disc (center, radius) is taken on the slave stream; the block then walks the
// columns from cx-r (floored at zero) to cx+r (capped at map_width-1) left to right
// and sends one span per column on the master stream: the rows cy-h .. cy+h clipped
// to the map, where h is
// the largest half-height with dx*dx + h*h <= r*r. A span clipped to nothing is still
// sent, with tuser set and both rows zero. tlast marks the last span of a disc. A
// disc whose column range misses the map yields no span at all. Radius saturates at
// MAX_RADIUS; map_width and map_height saturate at min(MAP_DIM, 256). All squares
// come from one shared squarer, one square per cycle. For a disc the block takes
// it, squares r, then per column squares dx, searches the half-height down while
// it is too large and then up while the next height still fits, and emits the
// span; the emit state waits while the output side stalls. s_axis_tready is high
// only while no disc is in work; the last span may still wait in the output
// register then.
// Configuration writes are single-cycle and must only happen while idle.
module disc_column_span_generator_core #(
	parameter int MAP_DIM    = dcsg_pkg::MAP_DIM_DEF,
	parameter int MAX_RADIUS = dcsg_pkg::MAX_RADIUS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  dcsg_pkg::cfg_index_t           cfg_index,
	input  dcsg_pkg::cfg_word_t            cfg_data,
	// disc input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] center_x, [15:8] center_y, [20:16] radius, [23:21] zero
	input  logic [dcsg_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// span output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] column_x, [15:8] span_first, [23:16] span_last
	output logic [dcsg_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [0] span_empty
	output logic                           m_axis_tuser,
	output logic                           m_axis_tlast
);

	import dcsg_pkg::*;

`include "disc_column_span_generator_core_macros.svh"

	// Operand width of the squarer: must hold radius + 1.
	localparam int RW = $clog2(MAX_RADIUS + 2);
	localparam int PW = 2 * RW;
	// Map dimensions saturate here.
	localparam int DIM_CAP = (MAP_DIM < 256) ? MAP_DIM : 256;
	localparam logic [8:0] DIM_CAP_V = 9'(DIM_CAP);
	localparam logic [7:0] RMAX_V    = 8'(MAX_RADIUS);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LIM  = 3'd1;
	localparam logic [2:0] S_DX   = 3'd2;
	localparam logic [2:0] S_DOWN = 3'd3;
	localparam logic [2:0] S_UP   = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]    state_q;
	logic [8:0]    map_width_q;
	logic [8:0]    map_height_q;
	logic [7:0]    cx_q;
	logic [7:0]    cy_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] h_q;
	logic [7:0]    x_q;
	logic [7:0]    end_q;
	logic [PW-1:0] lim_q;
	logic [PW-1:0] d2_q;

	logic          out_valid_q;
	logic [7:0]    out_col_q;
	logic [7:0]    out_first_q;
	logic [7:0]    out_last_row_q;
	logic          out_empty_q;
	logic          out_tlast_q;

	// Input decode
	logic [7:0] in_cx;
	logic [7:0] in_cy;
	logic [7:0] in_r8;
	logic [7:0] in_rsat;
	logic [8:0] w_eff;
	logic [8:0] h_eff;
	logic [7:0] x0;
	logic [8:0] x1_raw;
	logic [8:0] x1;
	logic       range_ok;
	logic       in_fire;

	assign in_cx   = s_axis_tdata[7:0];
	assign in_cy   = s_axis_tdata[15:8];
	assign in_r8   = {3'b000, s_axis_tdata[20:16]};
	assign in_rsat = (in_r8 > RMAX_V) ? RMAX_V : in_r8;

	assign w_eff = (map_width_q > DIM_CAP_V) ? DIM_CAP_V : map_width_q;
	assign h_eff = (map_height_q > DIM_CAP_V) ? DIM_CAP_V : map_height_q;

	assign x0       = (in_cx >= in_rsat) ? (in_cx - in_rsat) : 8'd0;
	assign x1_raw   = {1'b0, in_cx} + {1'b0, in_rsat};
	assign x1       = (x1_raw > (w_eff - 9'd1)) ? (w_eff - 9'd1) : x1_raw;
	// x0 never passes cx + r, so the range is empty only when x0 is off the map
	assign range_ok = (w_eff != 9'd0) && ({1'b0, x0} < w_eff);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Shared squarer and its compare against r*r
	logic [7:0]    adx;
	logic [RW-1:0] sq_op;
	logic [PW-1:0] sq_res;
	logic [PW:0]   sq_sum;
	logic          sq_over;

	assign adx = (x_q >= cx_q) ? (x_q - cx_q) : (cx_q - x_q);

	always_comb begin
		sq_op = h_q;
		unique case (state_q)
			S_LIM:   sq_op = r_q;
			S_DX:    sq_op = RW'(adx);
			S_UP:    sq_op = h_q + RW'(1);
			default: sq_op = h_q;
		endcase
	end

	assign sq_res  = {{RW{1'b0}}, sq_op} * {{RW{1'b0}}, sq_op};
	assign sq_sum  = {1'b0, sq_res} + {1'b0, d2_q};
	assign sq_over = sq_sum > {1'b0, lim_q};

	// Span clipping for the current column
	logic [7:0] h8;
	logic [7:0] lo;
	logic [8:0] hi_raw;
	logic [8:0] hi_c;
	logic       span_empty;
	logic       out_load;

	assign h8         = 8'(h_q);
	assign lo         = (cy_q >= h8) ? (cy_q - h8) : 8'd0;
	assign hi_raw     = {1'b0, cy_q} + {1'b0, h8};
	assign hi_c       = (hi_raw > (h_eff - 9'd1)) ? (h_eff - 9'd1) : hi_raw;
	assign span_empty = (h_eff == 9'd0) || ({1'b0, lo} > (h_eff - 9'd1));
	assign out_load   = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_REG_RESET;
			map_height_q <= MAP_REG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			end_q   <= '0;
			h_q     <= '0;
			r_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// drop discs that cover no column of the map
					if (in_fire && range_ok) begin
						state_q <= S_LIM;
						x_q     <= x0;
						end_q   <= x1[7:0];
						r_q     <= RW'(in_rsat);
						h_q     <= '0;
					end
				end
				S_LIM: begin
					state_q <= S_DX;
				end
				S_DX: begin
					state_q <= S_DOWN;
				end
				S_DOWN: begin
					// shrink while the current height falls outside the disc
					if (h_q != '0 && sq_over) begin
						h_q <= h_q - RW'(1);
					end else begin
						state_q <= S_UP;
					end
				end
				S_UP: begin
					// grow while the next height still fits
					if (h_q != r_q && !sq_over) begin
						h_q <= h_q + RW'(1);
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (x_q == end_q) begin
							state_q <= S_IDLE;
						end else begin
							x_q     <= x_q + 8'd1;
							state_q <= S_DX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Held disc and squares
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cx_q <= in_cx;
			cy_q <= in_cy;
		end
		if (state_q == S_LIM) begin
			lim_q <= sq_res;
			d2_q  <= '0;
		end
		if (state_q == S_DX) begin
			d2_q <= sq_res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q      <= x_q;
			out_first_q    <= span_empty ? 8'd0 : lo;
			out_last_row_q <= span_empty ? 8'd0 : hi_c[7:0];
			out_empty_q    <= span_empty;
			out_tlast_q    <= (x_q == end_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_last_row_q, out_first_q, out_col_q};
	assign m_axis_tuser  = out_empty_q;
	assign m_axis_tlast  = out_tlast_q;

	// Checks
	`DCSG_ASSERT_NOW(a_col_in_range, (state_q != S_IDLE), (x_q <= end_q), "column past end")
	`DCSG_ASSERT_NOW(a_h_le_r, (state_q != S_IDLE), (h_q <= r_q), "half-height above radius")
	`DCSG_ASSERT_NOW(a_mid_span_busy, (m_axis_tvalid && !m_axis_tlast), (state_q != S_IDLE),
		"non-final span while idle")
	`DCSG_ASSERT_NEXT(a_hold_cy, (in_fire), (cy_q == $past(in_cy)), "center row not held")

endmodule
